### sv/huv_pkg.sv
// Shared types and constants for the HTTP URL validator.
package huv_pkg;

  // Longest URL, in bytes, that is examined
  localparam int MAX_URL_LEN = 4096;
  // Byte position width: holds 0..MAX_URL_LEN
  localparam int POS_W = $clog2(MAX_URL_LEN + 1);

  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [16:0] PORT_SAT   = 17'd65536;

  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_H       = 8'h68;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_S       = 8'h73;

  // Result status codes, in no particular priority order
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_EMPTY      = 4'd1,
    ST_NUL        = 4'd2,
    ST_NO_SCHEME  = 4'd3,
    ST_BAD_SCHEME = 4'd4,
    ST_USERINFO   = 4'd5,
    ST_BAD_PORT   = 4'd6,
    ST_NO_HOST    = 4'd7,
    ST_FRAGMENT   = 4'd8,
    ST_TOO_LONG   = 4'd9
  } huv_status_t;

  // Parse phase of the current URL
  typedef enum logic [1:0] {
    PH_SCHEME = 2'd0,
    PH_HOST   = 2'd1,
    PH_PATH   = 2'd2
  } huv_phase_t;

  // One input word
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_url;
  } huv_item_t;

  // One result word
  typedef struct packed {
    huv_status_t status;
    logic [15:0] port_number;
    logic        port_given;
    logic [11:0] host_offset;
    logic [12:0] host_length;
    logic [12:0] path_offset;
    logic        path_defaulted;
    logic        https_scheme;
  } huv_result_t;

endpackage

### sv/huv_in_reg.sv
// Input word register with valid/ready handshake.
module huv_in_reg import huv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      url_valid,
  output logic      url_ready,
  input  huv_item_t item_in,
  output huv_item_t item,
  output logic      item_valid,
  input  logic      take
);

  // Accept when empty or when the held word is consumed this cycle
  assign url_ready = !item_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (url_ready) begin
      item_valid <= url_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (url_valid && url_ready) begin
      item <= item_in;
    end
  end

endmodule

### sv/huv_parser.sv
// Per-URL parse state and end-of-URL result logic.
module huv_parser import huv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  huv_item_t   item,
  input  logic        fire,
  output huv_result_t result
);

  // State registers
  logic [POS_W-1:0] byte_position;
  huv_phase_t       parse_phase;
  logic [1:0]       separator_match;
  logic [7:0]       scheme_chars [5];
  logic             nul_seen;
  logic             at_in_host;
  logic             hash_seen;
  logic [POS_W-1:0] host_begin;
  logic [POS_W-1:0] slash_position;
  logic [POS_W-1:0] colon_position;
  logic             colon_active;
  logic [16:0]      port_accumulator;
  logic             port_digits_ok;
  logic             bracket_seen;
  logic             scheme_good;
  logic             scheme_https;
  logic             too_long;

  // Values after the current word
  logic [POS_W-1:0] upd_position;
  huv_phase_t       upd_phase;
  logic [1:0]       upd_sep;
  logic             upd_nul;
  logic             upd_at;
  logic             upd_hash;
  logic [POS_W-1:0] upd_host_begin;
  logic [POS_W-1:0] upd_slash;
  logic [POS_W-1:0] upd_colon;
  logic             upd_colon_active;
  logic [16:0]      upd_acc;
  logic             upd_digits_ok;
  logic             upd_bracket;
  logic             upd_scheme_good;
  logic             upd_scheme_https;
  logic             upd_too_long;
  logic             scheme_we;

  logic [7:0]  c;
  logic [7:0]  c_lower;
  logic        digit_char;
  logic        http4;
  logic [19:0] acc_mul;

  // Byte classification
  assign c          = item.char_byte;
  assign c_lower    = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
  assign digit_char = (c >= CH_ZERO) && (c <= CH_NINE);
  assign acc_mul  = ({3'b000, port_accumulator} << 3) + ({3'b000, port_accumulator} << 1)
                  + {16'd0, c[3:0]};
  assign http4    = scheme_chars[0] == CH_H && scheme_chars[1] == CH_T
                 && scheme_chars[2] == CH_T && scheme_chars[3] == CH_P;

  // Next state: effect of one word
  always_comb begin
    upd_position     = byte_position;
    upd_phase        = parse_phase;
    upd_sep          = separator_match;
    upd_nul          = nul_seen;
    upd_at           = at_in_host;
    upd_hash         = hash_seen;
    upd_host_begin   = host_begin;
    upd_slash        = slash_position;
    upd_colon        = colon_position;
    upd_colon_active = colon_active;
    upd_acc          = port_accumulator;
    upd_digits_ok    = port_digits_ok;
    upd_bracket      = bracket_seen;
    upd_scheme_good  = scheme_good;
    upd_scheme_https = scheme_https;
    upd_too_long     = too_long;
    scheme_we        = 1'b0;
    if (item.has_char) begin
      if (byte_position >= POS_W'(MAX_URL_LEN)) begin
        upd_too_long = 1'b1;
      end else begin
        upd_position = byte_position + POS_W'(1);
        if (c == 8'h00) begin
          upd_nul = 1'b1;
        end
        if (parse_phase == PH_SCHEME) begin
          scheme_we = byte_position < POS_W'(5);
          if (separator_match == 2'd2 && c == CH_SLASH) begin
            // "://" complete: the colon sits at byte_position - 2
            upd_scheme_good  = (byte_position == POS_W'(6) && http4)
                            || (byte_position == POS_W'(7) && http4
                                && scheme_chars[4] == CH_S);
            upd_scheme_https = byte_position == POS_W'(7) && http4
                            && scheme_chars[4] == CH_S;
            upd_phase        = PH_HOST;
            upd_host_begin   = byte_position + POS_W'(1);
            upd_sep          = 2'd0;
          end else if (separator_match == 2'd1 && c == CH_SLASH) begin
            upd_sep = 2'd2;
          end else begin
            upd_sep = (c == CH_COLON) ? 2'd1 : 2'd0;
          end
        end else begin
          if (c == CH_HASH) begin
            upd_hash = 1'b1;
          end
          if (parse_phase == PH_HOST) begin
            if (c == CH_SLASH) begin
              upd_slash = byte_position;
              upd_phase = PH_PATH;
            end else begin
              if (c == CH_AT) begin
                upd_at = 1'b1;
              end
              if (c == CH_COLON) begin
                upd_colon        = byte_position;
                upd_colon_active = 1'b1;
                upd_acc          = '0;
                upd_digits_ok    = 1'b1;
              end else if (c == CH_RBRACK && !bracket_seen) begin
                upd_bracket      = 1'b1;
                upd_colon_active = 1'b0;
              end else if (colon_active) begin
                if (digit_char) begin
                  upd_acc = (acc_mul > {3'b000, PORT_SAT}) ? PORT_SAT : acc_mul[16:0];
                end else begin
                  upd_digits_ok = 1'b0;
                end
              end
            end
          end
        end
      end
    end
  end

  logic [POS_W-1:0] host_end;
  logic [POS_W-1:0] name_end;
  logic [POS_W-1:0] host_len;
  huv_status_t      status;

  // Outputs: status by priority and result fields
  always_comb begin
    host_end = (upd_phase == PH_PATH) ? upd_slash : upd_position;
    name_end = upd_colon_active ? upd_colon : host_end;
    host_len = (name_end > upd_host_begin) ? name_end - upd_host_begin : '0;
    if (upd_too_long) begin
      status = ST_TOO_LONG;
    end else if (upd_position == '0) begin
      status = ST_EMPTY;
    end else if (upd_nul) begin
      status = ST_NUL;
    end else if (upd_phase == PH_SCHEME) begin
      status = ST_NO_SCHEME;
    end else if (!upd_scheme_good) begin
      status = ST_BAD_SCHEME;
    end else if (upd_at) begin
      status = ST_USERINFO;
    end else if (upd_colon_active && (!upd_digits_ok || upd_acc == '0
                                      || upd_acc > PORT_MAX)) begin
      status = ST_BAD_PORT;
    end else if (host_len == '0) begin
      status = ST_NO_HOST;
    end else if (upd_hash) begin
      status = ST_FRAGMENT;
    end else begin
      status = ST_OK;
    end
    result = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.port_number    = upd_colon_active ? upd_acc[15:0]
                            : (upd_scheme_https ? PORT_HTTPS : PORT_HTTP);
      result.port_given     = upd_colon_active;
      result.host_offset    = upd_host_begin[11:0];
      result.host_length    = 13'(host_len);
      result.path_offset    = 13'(host_end);
      result.path_defaulted = upd_phase != PH_PATH;
      result.https_scheme   = upd_scheme_https;
    end
  end

  // State update; the final word of a URL returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (fire && item.end_of_url)) begin
      byte_position    <= '0;
      parse_phase      <= PH_SCHEME;
      separator_match  <= '0;
      nul_seen         <= 1'b0;
      at_in_host       <= 1'b0;
      hash_seen        <= 1'b0;
      host_begin       <= '0;
      slash_position   <= '0;
      colon_position   <= '0;
      colon_active     <= 1'b0;
      port_accumulator <= '0;
      port_digits_ok   <= 1'b1;
      bracket_seen     <= 1'b0;
      scheme_good      <= 1'b0;
      scheme_https     <= 1'b0;
      too_long         <= 1'b0;
    end else if (fire) begin
      byte_position    <= upd_position;
      parse_phase      <= upd_phase;
      separator_match  <= upd_sep;
      nul_seen         <= upd_nul;
      at_in_host       <= upd_at;
      hash_seen        <= upd_hash;
      host_begin       <= upd_host_begin;
      slash_position   <= upd_slash;
      colon_position   <= upd_colon;
      colon_active     <= upd_colon_active;
      port_accumulator <= upd_acc;
      port_digits_ok   <= upd_digits_ok;
      bracket_seen     <= upd_bracket;
      scheme_good      <= upd_scheme_good;
      scheme_https     <= upd_scheme_https;
      too_long         <= upd_too_long;
    end
  end

  // Scheme bytes, lowercased; cleared per URL
  always_ff @(posedge clk) begin
    if (rst || (fire && item.end_of_url)) begin
      for (int i = 0; i < 5; i++) begin
        scheme_chars[i] <= '0;
      end
    end else if (fire && scheme_we) begin
      scheme_chars[byte_position[2:0]] <= c_lower;
    end
  end

endmodule

### sv/huv_out_reg.sv
// Result register with valid/ready handshake.
module huv_out_reg import huv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  huv_result_t result_in,
  input  logic        load,
  output logic        free,
  output huv_result_t result,
  output logic        result_valid,
  input  logic        result_ready
);

  // Slot can take a new result when empty or being drained
  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

### sv/http_url_validator_core.sv
// Top level of the HTTP URL validator.
//
// Input channel (url_valid/url_ready): one word per URL byte, char_byte with
// has_char set; end_of_url marks the last word. A word with has_char low only
// carries the end mark (an empty URL).
// Result channel (result_valid/result_ready): one word per URL, sent for the
// word with end_of_url. status holds the first error by priority; on error all
// other fields are zero. Otherwise port, host and path positions are given.
// Path: a final input word is accepted into the input register, then parse
// logic writes its result into the result register once that slot is free.
// Throughput: one input word per cycle unless a final word waits on a full
// result register; the single parse stage updates per-URL state per word.
// Reset (rst, synchronous) empties both registers and clears parse state.
// When the receiver stalls, non-final words keep flowing; a final word waits
// in the input register while the result register is full, and the input
// channel holds off until that result is taken.
module http_url_validator_core import huv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        url_valid,
  output logic        url_ready,
  input  logic [7:0]  char_byte,
  input  logic        has_char,
  input  logic        end_of_url,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [3:0]  status,
  output logic [15:0] port_number,
  output logic        port_given,
  output logic [11:0] host_offset,
  output logic [12:0] host_length,
  output logic [12:0] path_offset,
  output logic        path_defaulted,
  output logic        https_scheme
);

  huv_item_t   item_in;
  huv_item_t   item;
  logic        item_valid;
  logic        take;
  logic        free;
  logic        load;
  huv_result_t parsed;
  huv_result_t result;

  assign item_in.char_byte  = char_byte;
  assign item_in.has_char   = has_char;
  assign item_in.end_of_url = end_of_url;

  // A word is parsed unless it is final and the result slot is busy
  assign take = item_valid && (!item.end_of_url || free);
  assign load = take && item.end_of_url;

  huv_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .url_valid  (url_valid),
    .url_ready  (url_ready),
    .item_in    (item_in),
    .item       (item),
    .item_valid (item_valid),
    .take       (take)
  );

  huv_parser u_parse (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .fire   (take),
    .result (parsed)
  );

  huv_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .result_in    (parsed),
    .load         (load),
    .free         (free),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  assign status         = result.status;
  assign port_number    = result.port_number;
  assign port_given     = result.port_given;
  assign host_offset    = result.host_offset;
  assign host_length    = result.host_length;
  assign path_offset    = result.path_offset;
  assign path_defaulted = result.path_defaulted;
  assign https_scheme   = result.https_scheme;

`ifndef SYNTHESIS
  // No result comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Error results carry no port or offsets
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |->
      port_number == '0 && host_length == '0 && host_offset == '0 && !port_given)
    else $error("error result with nonzero fields");

  // Good results have a real port and a non-empty host
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK |-> port_number != '0 && host_length != '0)
    else $error("ok result with zero port or host");

  // Input stalls only while a word is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !url_ready |-> item_valid && item.end_of_url && result_valid)
    else $error("input stalled without cause");
`endif

endmodule
